### rtl/bole_pkg.sv
`default_nettype none

package bole_pkg;

  // request commands
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_DELETE  = 2'd1;
  localparam logic [1:0] CMD_SEARCH  = 2'd2;
  localparam logic [1:0] CMD_REVERSE = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // what a cell loads at the next edge
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_MIRROR
  } cell_op_t;

endpackage

`default_nettype wire

### rtl/bole_cell.sv
`default_nettype none

module bole_cell #(
  parameter int WORD_BITS = 32
) (
  input  wire                   clk,
  input  bole_pkg::cell_op_t    op,
  input  wire  [WORD_BITS-1:0]  load_word,
  input  wire  [WORD_BITS-1:0]  left_word,
  input  wire  [WORD_BITS-1:0]  right_word,
  input  wire  [WORD_BITS-1:0]  mirror_word,
  input  wire                   live,
  input  wire                   cmp_en,
  output logic [WORD_BITS-1:0]  word,
  output logic                  hit
);
  import bole_pkg::*;

  logic [WORD_BITS-1:0] word_next;

  // source select for the stored word
  always_comb begin
    case (op)
      CELL_HOLD:       word_next = word;
      CELL_LOAD:       word_next = load_word;
      CELL_FROM_LEFT:  word_next = left_word;
      CELL_FROM_RIGHT: word_next = right_word;
      CELL_MIRROR:     word_next = mirror_word;
      default:         word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // local match flag, only for occupied cells
  always_ff @(posedge clk) begin
    hit <= cmp_en && live && (word == load_word);
  end

endmodule

`default_nettype wire

### rtl/bounded_ordered_list_engine.sv
// Ordered list of up to CAPACITY signed words held in a row of cells, one
// word per cell. A request is taken when start is high and busy is low; its
// result appears on found, list_length and status for exactly one cycle
// while done is high, and must be taken then since the block cannot be
// stalled. Insert and delete shift the cells at and past the chosen position
// together, and the result follows in the cycle after the request.
// Search compares all cells at once and ORs the registered match flags into
// the registered result. Reverse mirrors the whole row at once and then
// slides it toward the head one cell per cycle, CAPACITY - list_length times,
// before its result comes; a full list, or a list of one element or less,
// skips the slide. A new request may be given in the cycle that done is high.
`default_nettype none

module bounded_ordered_list_engine #(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  cmd,
  input  wire  [6:0]  position,
  input  wire  [31:0] value,
  output logic        done,
  output logic        found,
  output logic [6:0]  list_length,
  output logic [1:0]  status
);
  import bole_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 7) ? CW : 7;
  localparam int XW = (WORD_BITS > 32) ? WORD_BITS : 32;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] remain;
  logic [CW-1:0] remain_next;
  logic          done_next;
  logic          found_next;
  logic [1:0]    status_next;

  logic                 acc;
  logic                 full;
  logic                 empty;
  logic [PW-1:0]        pos_x;
  logic [PW-1:0]        cnt_x;
  logic [PW-1:0]        ins_pos;
  logic [PW-1:0]        del_pos;
  logic [XW-1:0]        value_x;
  logic [WORD_BITS-1:0] load_word;
  logic                 do_insert;
  logic                 do_delete;
  logic                 do_mirror;

  logic [WORD_BITS-1:0] words [CAPACITY];
  logic [CAPACITY-1:0]  hits;

  // request decode
  assign busy      = (state != S_IDLE);
  assign acc       = start && !busy;
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign pos_x     = PW'(position);
  assign cnt_x     = PW'(count);
  assign ins_pos   = (pos_x > cnt_x) ? cnt_x : pos_x;
  assign del_pos   = (pos_x > cnt_x - PW'(1)) ? cnt_x - PW'(1) : pos_x;
  assign value_x   = XW'($signed(value));
  assign load_word = value_x[WORD_BITS-1:0];
  assign do_insert = acc && (cmd == CMD_INSERT) && !full;
  assign do_delete = acc && (cmd == CMD_DELETE) && !empty;
  assign do_mirror = acc && (cmd == CMD_REVERSE) && (count > CW'(1));

  assign list_length = cnt_x[6:0];

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [PW-1:0] IDX = PW'(i);
    cell_op_t             op;
    logic [WORD_BITS-1:0] left_word;
    logic [WORD_BITS-1:0] right_word;

    assign left_word  = (i == 0) ? words[i] : words[(i == 0) ? 0 : i - 1];
    assign right_word = (i == CAPACITY - 1) ? words[i]
                                            : words[(i == CAPACITY - 1) ? i : i + 1];

    // per-cell operation from its place relative to the request position
    always_comb begin
      op = CELL_HOLD;
      if (state == S_SHIFT) begin
        op = CELL_FROM_RIGHT;
      end else if (do_insert) begin
        if (IDX == ins_pos) begin
          op = CELL_LOAD;
        end else if (IDX > ins_pos) begin
          op = CELL_FROM_LEFT;
        end
      end else if (do_delete) begin
        if (IDX >= del_pos) begin
          op = CELL_FROM_RIGHT;
        end
      end else if (do_mirror) begin
        op = CELL_MIRROR;
      end
    end

    bole_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk         (clk),
      .op          (op),
      .load_word   (load_word),
      .left_word   (left_word),
      .right_word  (right_word),
      .mirror_word (words[CAPACITY-1-i]),
      .live        (IDX < cnt_x),
      .cmp_en      (acc && (cmd == CMD_SEARCH)),
      .word        (words[i]),
      .hit         (hits[i])
    );
  end

  // sequencer and result registers
  always_comb begin
    state_next  = state;
    count_next  = count;
    remain_next = remain;
    done_next   = 1'b0;
    found_next  = found;
    status_next = status;
    case (state)
      S_IDLE: begin
        if (acc) begin
          found_next  = 1'b0;
          status_next = STAT_OK;
          case (cmd)
            CMD_INSERT: begin
              done_next = 1'b1;
              if (full) begin
                status_next = STAT_FULL;
              end else begin
                count_next = count + CW'(1);
              end
            end
            CMD_DELETE: begin
              done_next = 1'b1;
              if (empty) begin
                status_next = STAT_EMPTY;
              end else begin
                count_next = count - CW'(1);
              end
            end
            CMD_SEARCH: begin
              state_next = S_SEARCH;
            end
            default: begin
              remain_next = CW'(CAPACITY) - count;
              if (do_mirror && !full) begin
                state_next = S_SHIFT;
              end else begin
                done_next = 1'b1;
              end
            end
          endcase
        end
      end
      S_SEARCH: begin
        found_next = |hits;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      S_SHIFT: begin
        remain_next = remain - CW'(1);
        if (remain == CW'(1)) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    remain <= remain_next;
    found  <= found_next;
    status <= status_next;
  end

endmodule

`default_nettype wire

### rtl/bole_checker.sv
`default_nettype none

module bole_checker #(
  parameter int CAPACITY = 64
) (
  input wire        clk,
  input wire        rst,
  input wire        start,
  input wire        busy,
  input wire        done,
  input wire        found,
  input wire  [6:0] list_length,
  input wire  [1:0] status
);
  import bole_pkg::*;

  // every result follows a request or a busy cycle
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result strobe without a pending request");

  // only defined status codes are reported
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == STAT_OK || status == STAT_FULL || status == STAT_EMPTY))
    else $error("undefined status code");

  // a dropped insert means the list is full
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_FULL) |-> (list_length == 7'(CAPACITY)))
    else $error("insert dropped while list not full");

  // a failed delete means the list is empty, and hits come only with success
  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STAT_EMPTY || found)) |->
      ((status == STAT_EMPTY) ? (list_length == 7'd0) : (status == STAT_OK)))
    else $error("status inconsistent with length or search hit");

endmodule

bind bounded_ordered_list_engine bole_checker #(
  .CAPACITY (CAPACITY)
) u_bole_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .found       (found),
  .list_length (list_length),
  .status      (status)
);

`default_nettype wire

### tb/bounded_ordered_list_engine_checker.sv
module bounded_ordered_list_engine_checker #(
  parameter int CAPACITY = 64
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  input  wire        busy,
  input  wire [1:0]  cmd,
  input  wire [6:0]  position,
  input  wire [31:0] value,
  input  wire        done,
  input  wire        found,
  input  wire [6:0]  list_length,
  input  wire [1:0]  status,
  output int         fail_count,
  output int         pending
);
  import bole_pkg::*;

  // one result as the block should report it
  typedef struct packed {
    logic       found;
    logic [6:0] length;
    logic [1:0] status;
  } list_result_t;

  list_result_t      expected_results[$];
  logic signed [31:0] shadow_list[CAPACITY];
  int                 shadow_count;

  initial begin
    fail_count   = 0;
    pending      = 0;
    shadow_count = 0;
  end

  // apply one request to the shadow list and return its result
  function automatic list_result_t apply_request(logic [1:0] op, logic [6:0] pos,
                                                 logic [31:0] word);
    list_result_t      res;
    int                p;
    int                lo;
    int                hi;
    logic signed [31:0] t;
    res.found  = 1'b0;
    res.status = STAT_OK;
    p = pos;
    case (op)
      CMD_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          if (p > shadow_count) p = shadow_count;
          for (int i = shadow_count; i > p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p] = word;
          shadow_count++;
        end
      end
      CMD_DELETE: begin
        if (shadow_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          if (p > shadow_count - 1) p = shadow_count - 1;
          for (int i = p; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
      end
      CMD_SEARCH: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_list[i] == word) res.found = 1'b1;
        end
      end
      default: begin
        lo = 0;
        hi = shadow_count - 1;
        while (lo < hi) begin
          t              = shadow_list[lo];
          shadow_list[lo] = shadow_list[hi];
          shadow_list[hi] = t;
          lo++;
          hi--;
        end
      end
    endcase
    res.length = shadow_count[6:0];
    return res;
  endfunction

  // count a failure and print it
  task automatic report_mismatch(string what, longint want, longint got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  // compare results first, then predict the request taken at this edge
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      expected_results.delete();
      shadow_count = 0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, list_length", -1, list_length);
        end else begin
          want = expected_results.pop_front();
          if (found !== want.found) report_mismatch("found", want.found, found);
          if (list_length !== want.length)
            report_mismatch("list_length", want.length, list_length);
          if (status !== want.status) report_mismatch("status", want.status, status);
        end
      end
      if (start && !busy) begin
        expected_results.push_back(apply_request(cmd, position, value));
      end
    end
    pending = expected_results.size();
  end

endmodule

### tb/bounded_ordered_list_engine_tb.sv
module bounded_ordered_list_engine_tb;
  import bole_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int RANDOM_ITEMS = 880;
  localparam int PHASE_ITEMS  = 100;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        start    = 1'b0;
  logic [1:0]  cmd      = CMD_INSERT;
  logic [6:0]  position = '0;
  logic [31:0] value    = '0;
  wire         busy;
  wire         done;
  wire         found;
  wire  [6:0]  list_length;
  wire  [1:0]  status;
  int          fail_count;
  int          pending;

  // small pool of words so that searches hit now and then
  logic [31:0] word_pool[8] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                                32'h0000_0001, 32'h5555_aaaa, 32'haaaa_5555, 32'h1234_5678};

  bounded_ordered_list_engine #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (32)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .position    (position),
    .value       (value),
    .done        (done),
    .found       (found),
    .list_length (list_length),
    .status      (status)
  );

  bounded_ordered_list_engine_checker #(
    .CAPACITY (CAPACITY)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .position    (position),
    .value       (value),
    .done        (done),
    .found       (found),
    .list_length (list_length),
    .status      (status),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // clock, period 12
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  initial begin
    #12000000;
    $display("Some tests failed");
    $finish;
  end

  // hold a request until the block takes it
  task automatic send_request(logic [1:0] op, logic [6:0] pos, logic [31:0] word);
    start    <= 1'b1;
    cmd      <= op;
    position <= pos;
    value    <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // random idle time after a request, junk on the fields meanwhile
  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 65) n = 0;
    else if (r < 94) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      start    <= 1'b0;
      cmd      <= 2'($urandom_range(0, 3));
      position <= 7'($urandom_range(0, 127));
      value    <= $urandom();
      repeat (n) @(posedge clk);
    end
  endtask

  // command mix per phase: 0 fill, 1 drain, 2 mixed
  function automatic logic [1:0] pick_cmd(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0:       return (r < 85) ? CMD_INSERT : (r < 90) ? CMD_DELETE :
                      (r < 97) ? CMD_SEARCH : CMD_REVERSE;
      1:       return (r < 80) ? CMD_DELETE : (r < 88) ? CMD_INSERT :
                      (r < 96) ? CMD_SEARCH : CMD_REVERSE;
      default: return (r < 35) ? CMD_INSERT : (r < 65) ? CMD_DELETE :
                      (r < 90) ? CMD_SEARCH : CMD_REVERSE;
    endcase
  endfunction

  function automatic logic [6:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 7'd0;
    if (r < 85) return 7'($urandom_range(0, 66));
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [31:0] pick_word();
    if ($urandom_range(0, 1) == 0) return word_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  initial begin
    int mode;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list corners, extremes, head, middle and tail
    send_request(CMD_SEARCH,  7'd0,   32'h0000_0000);
    send_request(CMD_DELETE,  7'd0,   32'h0000_0000);
    send_request(CMD_REVERSE, 7'd0,   32'h0000_0000);
    send_request(CMD_INSERT,  7'd0,   32'h7fff_ffff);
    send_request(CMD_REVERSE, 7'd0,   32'h0000_0000);
    send_request(CMD_SEARCH,  7'd0,   32'h7fff_ffff);
    send_request(CMD_INSERT,  7'd127, 32'h8000_0000);
    send_request(CMD_INSERT,  7'd1,   32'h0000_0000);
    send_request(CMD_INSERT,  7'd64,  32'hffff_ffff);
    send_request(CMD_SEARCH,  7'd127, 32'h8000_0000);
    send_request(CMD_SEARCH,  7'd0,   32'h0000_0001);
    send_request(CMD_REVERSE, 7'd127, 32'hffff_ffff);
    send_request(CMD_SEARCH,  7'd0,   32'hffff_ffff);
    send_request(CMD_DELETE,  7'd1,   32'h0000_0000);
    send_request(CMD_DELETE,  7'd127, 32'h0000_0000);
    send_request(CMD_DELETE,  7'd0,   32'h0000_0000);
    send_request(CMD_DELETE,  7'd5,   32'hffff_ffff);
    send_request(CMD_DELETE,  7'd127, 32'h0000_0000);
    send_request(CMD_SEARCH,  7'd0,   32'h8000_0000);
    idle_gap();

    // random phases that fill, drain or churn the list
    mode = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0 && n > 0) mode = $urandom_range(0, 2);
      send_request(pick_cmd(mode), pick_position(), pick_word());
      idle_gap();
    end
    start <= 1'b0;

    // drain, then allow for the longest reverse
    while (pending != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/bole_pkg.sv
rtl/bole_cell.sv
rtl/bounded_ordered_list_engine.sv
rtl/bole_checker.sv
tb/bounded_ordered_list_engine_checker.sv
tb/bounded_ordered_list_engine_tb.sv
